// File: sv/mwtsr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mixed-width text span raster core
// no dependencies; used by every module of the core

package mwtsr_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_FETCH = 2'd0,
      KIND_SPAN  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // input actions
   typedef enum logic [1:0] {
      ACT_TEXT    = 2'd0,
      ACT_GLYPH   = 2'd1,
      ACT_NEWLINE = 2'd2
   } action_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_ORIGIN_ROW = 2'd0,
      CSR_ORIGIN_COL = 2'd1,
      CSR_TEXT_COLOR = 2'd2,
      CSR_SCALE      = 2'd3
   } csr_index_type;

   localparam logic [7:0]  CODE_LOW  = 8'hA1;
   localparam logic [7:0]  CODE_HIGH = 8'hFE;
   localparam logic [13:0] ROW_CODES = 14'd94;
   localparam logic [8:0]  ASC_LEN   = 9'd144;
   localparam logic [8:0]  HZ_LEN    = 9'd288;
   localparam logic [7:0]  CELL_COLS = 8'd24;
   localparam logic [12:0] PEN_MAX   = 13'h1FFF;

   // unsaturated span base coordinates
   localparam int BASE_BITS = 17;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCNT_BITS   = 3;

   typedef struct packed {
      logic [11:0] origin_row;
      logic [11:0] origin_col;
      logic [23:0] text_color;
      logic [3:0]  scale;
   } cfg_type;

   // one command for the back end: a fetch, an error or a glyph byte to expand
   typedef struct packed {
      kind_type              kind;
      logic [21:0]           fetch_address;
      logic [8:0]            fetch_length;
      logic [BASE_BITS-1:0]  row_base;
      logic [BASE_BITS-1:0]  col_base;
      logic [7:0]            bits;
      logic [3:0]            span_scale;
   } cmd_type;

endpackage

// File: sv/mwtsr_front.sv
`timescale 1ns / 1ps
// front end: takes text, glyph and new-line beats, keeps pen and glyph state,
// turns each beat into at most one command; depends on mwtsr_pkg

module mwtsr_front #(
   parameter int COORD_BITS = 13,
   parameter int MAX_SCALE  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [1:0]         in_action,
   input  logic [7:0]         in_byte,
   input  mwtsr_pkg::cfg_type cfg,
   output logic               push_valid,
   input  logic               push_ready,
   output mwtsr_pkg::cmd_type push_cmd
);

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
   localparam int BB = mwtsr_pkg::BASE_BITS;

   logic [12:0]           pen_ff, pen_in;
   logic                  lead_pending_ff, lead_pending_in;
   logic [7:0]            lead_byte_ff, lead_byte_in;
   logic                  double_ff, double_in;
   logic [8:0]            left_ff, left_in;
   logic [5:0]            dot_row_ff, dot_row_in;
   logic [2:0]            row_byte_ff, row_byte_in;
   logic [COORD_BITS-1:0] origin_ff, origin_in;

   logic                  accept;
   logic [3:0]            scale_eff;
   logic [7:0]            cell_cols;
   logic [20:0]           pen_cols;
   logic [21:0]           origin_sum;
   logic [COORD_BITS-1:0] new_origin;
   logic                  pair_ok;
   logic [13:0]           row_code, col_code, hz_index;
   logic [21:0]           hz_addr, asc_addr;
   logic [13:0]           pen_sum1, pen_sum2;
   logic [12:0]           pen_sat1, pen_sat2;
   logic [2:0]            row_byte_last;
   logic [BB-1:0]         row_base, col_base;

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      if (cfg.scale == 4'd0) begin
         scale_eff = 4'd1;
      end else if (cfg.scale > 4'(MAX_SCALE)) begin
         scale_eff = 4'(MAX_SCALE);
      end else begin
         scale_eff = cfg.scale;
      end
   end

   // left edge of a new glyph
   assign cell_cols  = 8'(scale_eff) * mwtsr_pkg::CELL_COLS;
   assign pen_cols   = 21'(pen_ff) * 21'(cell_cols);
   assign origin_sum = 22'(cfg.origin_col) + 22'(pen_cols);
   assign new_origin = (origin_sum > 22'(COORD_MAX)) ? COORD_MAX
                                                     : origin_sum[COORD_BITS-1:0];

   assign pair_ok = (lead_byte_ff >= mwtsr_pkg::CODE_LOW) &&
                    (lead_byte_ff <= mwtsr_pkg::CODE_HIGH) &&
                    (in_byte >= mwtsr_pkg::CODE_LOW) &&
                    (in_byte <= mwtsr_pkg::CODE_HIGH);
   assign row_code = 14'(lead_byte_ff - mwtsr_pkg::CODE_LOW);
   assign col_code = 14'(in_byte - mwtsr_pkg::CODE_LOW);
   assign hz_index = 14'(row_code[6:0] * mwtsr_pkg::ROW_CODES) + 14'(col_code[6:0]);
   assign hz_addr  = 22'(hz_index) * 22'(mwtsr_pkg::HZ_LEN);
   assign asc_addr = 22'(in_byte) * 22'(mwtsr_pkg::ASC_LEN);

   assign pen_sum1 = {1'b0, pen_ff} + 14'd1;
   assign pen_sum2 = {1'b0, pen_ff} + 14'd2;
   assign pen_sat1 = pen_sum1[13] ? mwtsr_pkg::PEN_MAX : pen_sum1[12:0];
   assign pen_sat2 = pen_sum2[13] ? mwtsr_pkg::PEN_MAX : pen_sum2[12:0];

   assign row_byte_last = double_ff ? 3'd5 : 3'd2;
   assign row_base = BB'(cfg.origin_row) + BB'(dot_row_ff) * BB'(scale_eff);
   assign col_base = BB'(origin_ff) + ((BB'(row_byte_ff) * BB'(scale_eff)) << 3);

   always_comb begin
      pen_in          = pen_ff;
      lead_pending_in = lead_pending_ff;
      lead_byte_in    = lead_byte_ff;
      double_in       = double_ff;
      left_in         = left_ff;
      dot_row_in      = dot_row_ff;
      row_byte_in     = row_byte_ff;
      origin_in       = origin_ff;

      push_valid             = 1'b0;
      push_cmd.kind          = mwtsr_pkg::KIND_FETCH;
      push_cmd.fetch_address = '0;
      push_cmd.fetch_length  = '0;
      push_cmd.row_base      = row_base;
      push_cmd.col_base      = col_base;
      push_cmd.bits          = in_byte;
      push_cmd.span_scale    = scale_eff;

      if (accept) begin
         unique case (mwtsr_pkg::action_type'(in_action))
            mwtsr_pkg::ACT_TEXT: begin
               if (lead_pending_ff) begin
                  lead_pending_in = 1'b0;
                  pen_in          = pen_sat2;
                  push_valid      = 1'b1;
                  if (pair_ok) begin
                     double_in              = 1'b1;
                     left_in                = mwtsr_pkg::HZ_LEN;
                     dot_row_in             = '0;
                     row_byte_in            = '0;
                     origin_in              = new_origin;
                     push_cmd.fetch_address = hz_addr;
                     push_cmd.fetch_length  = mwtsr_pkg::HZ_LEN;
                  end else begin
                     push_cmd.kind = mwtsr_pkg::KIND_ERROR;
                  end
               end else if (in_byte[7]) begin
                  lead_pending_in = 1'b1;
                  lead_byte_in    = in_byte;
               end else begin
                  double_in              = 1'b0;
                  left_in                = 9'(mwtsr_pkg::ASC_LEN);
                  dot_row_in             = '0;
                  row_byte_in            = '0;
                  origin_in              = new_origin;
                  pen_in                 = pen_sat1;
                  push_valid             = 1'b1;
                  push_cmd.fetch_address = asc_addr;
                  push_cmd.fetch_length  = mwtsr_pkg::ASC_LEN;
               end
            end
            mwtsr_pkg::ACT_GLYPH: begin
               if (left_ff != 9'd0) begin
                  left_in = left_ff - 9'd1;
                  if (row_byte_ff == row_byte_last) begin
                     row_byte_in = '0;
                     dot_row_in  = dot_row_ff + 6'd1;
                  end else begin
                     row_byte_in = row_byte_ff + 3'd1;
                  end
                  // an empty byte is counted but draws nothing
                  if (in_byte != 8'd0) begin
                     push_valid    = 1'b1;
                     push_cmd.kind = mwtsr_pkg::KIND_SPAN;
                  end
               end
            end
            mwtsr_pkg::ACT_NEWLINE: begin
               pen_in          = '0;
               lead_pending_in = 1'b0;
               left_in         = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff          <= '0;
         lead_pending_ff <= 1'b0;
         lead_byte_ff    <= '0;
         double_ff       <= 1'b0;
         left_ff         <= '0;
         dot_row_ff      <= '0;
         row_byte_ff     <= '0;
         origin_ff       <= '0;
      end else begin
         pen_ff          <= pen_in;
         lead_pending_ff <= lead_pending_in;
         lead_byte_ff    <= lead_byte_in;
         double_ff       <= double_in;
         left_ff         <= left_in;
         dot_row_ff      <= dot_row_in;
         row_byte_ff     <= row_byte_in;
         origin_ff       <= origin_in;
      end
   end

endmodule

// File: sv/mwtsr_cmd_queue.sv
`timescale 1ns / 1ps
// small command queue between front end and back end
// depends on mwtsr_pkg for the command type and depth

module mwtsr_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mwtsr_pkg::cmd_type push_cmd,
   output logic               head_valid,
   input  logic               pop,
   output mwtsr_pkg::cmd_type head_cmd
);

   mwtsr_pkg::cmd_type mem [mwtsr_pkg::QUEUE_DEPTH];

   logic [mwtsr_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mwtsr_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mwtsr_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                            do_push, do_pop;

   assign push_ready = count_ff != mwtsr_pkg::QCNT_BITS'(mwtsr_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/mwtsr_back.sv
`timescale 1ns / 1ps
// back end: walks the queue head command and emits one result per cycle
// when not stalled, into a registered output stage; depends on mwtsr_pkg

module mwtsr_back #(
   parameter int COORD_BITS = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  mwtsr_pkg::cmd_type    head_cmd,
   output logic                  pop,
   input  logic [23:0]           text_color,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mwtsr_pkg::kind_type   out_kind,
   output logic [21:0]           out_fetch_address,
   output logic [8:0]            out_fetch_length,
   output logic [COORD_BITS-1:0] out_span_row,
   output logic [COORD_BITS-1:0] out_span_col,
   output logic [3:0]            out_span_length,
   output logic [23:0]           out_span_color,
   output logic                  out_last
);

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

   logic                  active_ff, active_in;
   logic [7:0]            mask_ff, mask_in;
   logic [2:0]            rep_ff, rep_in;
   logic                  valid_ff, valid_in;

   mwtsr_pkg::kind_type   kind_ff;
   logic [21:0]           addr_ff;
   logic [8:0]            len_ff;
   logic [COORD_BITS-1:0] row_ff, col_ff;
   logic [3:0]            slen_ff;
   logic [23:0]           color_ff;
   logic                  last_ff;

   logic [7:0]            cur_mask, mask_next;
   logic [2:0]            cur_rep, bit_pos, dot;
   logic                  rep_done, span_last, res_last, is_span, advance;
   logic [17:0]           row_sum, col_sum;
   logic [COORD_BITS-1:0] row_sat, col_sat;

   assign is_span  = head_cmd.kind == mwtsr_pkg::KIND_SPAN;
   assign cur_mask = active_ff ? mask_ff : head_cmd.bits;
   assign cur_rep  = active_ff ? rep_ff : 3'd0;

   // highest set bit is drawn first
   always_comb begin
      bit_pos = '0;
      for (int i = 0; i < 8; i++) begin
         if (cur_mask[i]) begin
            bit_pos = 3'(i);
         end
      end
   end

   assign dot       = ~bit_pos;
   assign rep_done  = 4'(cur_rep) == (head_cmd.span_scale - 4'd1);
   assign mask_next = rep_done ? (cur_mask & ~(8'd1 << bit_pos)) : cur_mask;
   assign span_last = rep_done && (mask_next == 8'd0);
   assign res_last  = is_span ? span_last : 1'b1;

   assign row_sum = 18'(head_cmd.row_base) + 18'(cur_rep);
   assign col_sum = 18'(head_cmd.col_base) + 18'(dot) * 18'(head_cmd.span_scale);
   assign row_sat = (row_sum > 18'(COORD_MAX)) ? COORD_MAX : row_sum[COORD_BITS-1:0];
   assign col_sat = (col_sum > 18'(COORD_MAX)) ? COORD_MAX : col_sum[COORD_BITS-1:0];

   assign advance = head_valid && (!valid_ff || out_ready);
   assign pop     = advance && res_last;

   always_comb begin
      active_in = active_ff;
      mask_in   = mask_ff;
      rep_in    = rep_ff;
      valid_in  = valid_ff;
      if (advance) begin
         valid_in  = 1'b1;
         active_in = !res_last;
         mask_in   = mask_next;
         rep_in    = rep_done ? 3'd0 : cur_rep + 3'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         mask_ff   <= '0;
         rep_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         mask_ff   <= mask_in;
         rep_ff    <= rep_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff  <= head_cmd.kind;
         addr_ff  <= head_cmd.fetch_address;
         len_ff   <= head_cmd.fetch_length;
         row_ff   <= is_span ? row_sat : '0;
         col_ff   <= is_span ? col_sat : '0;
         slen_ff  <= is_span ? head_cmd.span_scale : 4'd0;
         color_ff <= is_span ? text_color : 24'd0;
         last_ff  <= res_last;
      end
   end

   assign out_valid         = valid_ff;
   assign out_kind          = kind_ff;
   assign out_fetch_address = addr_ff;
   assign out_fetch_length  = len_ff;
   assign out_span_row      = row_ff;
   assign out_span_col      = col_ff;
   assign out_span_length   = slen_ff;
   assign out_span_color    = color_ff;
   assign out_last          = last_ff;

endmodule

// File: sv/mixed_width_text_span_raster_core.sv
`timescale 1ns / 1ps
// top level of the mixed-width text span raster core: configuration registers,
// front end, command queue and back end; depends on mwtsr_pkg and the mwtsr_ modules

// Text and glyph beats enter on req_ and are taken one per cycle while the
// four-entry command queue has room; a text beat yields one font fetch or
// error result, a lead byte or new line yields none. Results leave on rsp_,
// one per cycle while results are pending and rsp_ready is high, from a
// registered output stage: a fetch or error is a single result, a glyph byte
// yields (set bits) * scale spans, so full bytes at a large scale hold the back
// end while the queue fills and stalls req_. The back end's span walk sets the
// sustained rate. The user must write configuration through csr_ only while the core is idle; it is not enforced.

module mixed_width_text_span_raster_core #(
   parameter int MAX_SCALE  = 8,
   parameter int COORD_BITS = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   // input beats
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_data_byte,
   // result beats
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [21:0]           rsp_fetch_address,
   output logic [8:0]            rsp_fetch_length,
   output logic [COORD_BITS-1:0] rsp_span_row,
   output logic [COORD_BITS-1:0] rsp_span_col,
   output logic [3:0]            rsp_span_length,
   output logic [23:0]           rsp_span_color,
   output logic                  rsp_last,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_data
);

   // configuration registers
   logic [11:0] origin_row_ff, origin_row_in;
   logic [11:0] origin_col_ff, origin_col_in;
   logic [23:0] text_color_ff, text_color_in;
   logic [3:0]  scale_ff, scale_in;

   mwtsr_pkg::cfg_type  cfg;
   mwtsr_pkg::cmd_type  push_cmd, head_cmd;
   mwtsr_pkg::kind_type out_kind;
   logic                push_valid, push_ready, head_valid, pop;

   // writes are always accepted and land in the register
   assign csr_ready = 1'b1;

   always_comb begin
      origin_row_in = origin_row_ff;
      origin_col_in = origin_col_ff;
      text_color_in = text_color_ff;
      scale_in      = scale_ff;
      if (csr_valid && csr_ready) begin
         unique case (mwtsr_pkg::csr_index_type'(csr_index))
            mwtsr_pkg::CSR_ORIGIN_ROW: origin_row_in = csr_data[11:0];
            mwtsr_pkg::CSR_ORIGIN_COL: origin_col_in = csr_data[11:0];
            mwtsr_pkg::CSR_TEXT_COLOR: text_color_in = csr_data;
            mwtsr_pkg::CSR_SCALE:      scale_in      = csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_row_ff <= '0;
         origin_col_ff <= '0;
         text_color_ff <= 24'hFFFFFF;
         scale_ff      <= 4'd1;
      end else begin
         origin_row_ff <= origin_row_in;
         origin_col_ff <= origin_col_in;
         text_color_ff <= text_color_in;
         scale_ff      <= scale_in;
      end
   end

   assign cfg.origin_row = origin_row_ff;
   assign cfg.origin_col = origin_col_ff;
   assign cfg.text_color = text_color_ff;
   assign cfg.scale      = scale_ff;

   // front end: pen, pending lead byte, active glyph position
   mwtsr_front #(
      .COORD_BITS (COORD_BITS),
      .MAX_SCALE  (MAX_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_action  (req_action),
      .in_byte    (req_data_byte),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decouples beat intake from span output
   mwtsr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .head_valid (head_valid),
      .pop        (pop),
      .head_cmd   (head_cmd)
   );

   // back end: one result per cycle unless stalled; spans walked by bit and by row
   mwtsr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .text_color        (text_color_ff),
      .out_valid         (rsp_valid),
      .out_ready         (rsp_ready),
      .out_kind          (out_kind),
      .out_fetch_address (rsp_fetch_address),
      .out_fetch_length  (rsp_fetch_length),
      .out_span_row      (rsp_span_row),
      .out_span_col      (rsp_span_col),
      .out_span_length   (rsp_span_length),
      .out_span_color    (rsp_span_color),
      .out_last          (rsp_last)
   );

   assign rsp_kind = out_kind;

`ifndef ASSERT_OFF
   // output stage comes up empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // span beats carry an effective scale as their length
   a_span_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mwtsr_pkg::KIND_SPAN |->
         rsp_span_length != 4'd0 && rsp_span_length <= 4'(MAX_SCALE) &&
         rsp_fetch_length == 9'd0)
      else $error("span beat with bad length or fetch fields");

   // fetch and error beats are single, final and carry no span
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != mwtsr_pkg::KIND_SPAN |->
         rsp_last && rsp_span_length == 4'd0 && rsp_span_color == 24'd0)
      else $error("fetch or error beat not final or carries span fields");

   // fetch lengths are those of the two glyph sizes
   a_fetch_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == mwtsr_pkg::KIND_FETCH |->
         rsp_fetch_length == mwtsr_pkg::ASC_LEN || rsp_fetch_length == mwtsr_pkg::HZ_LEN)
      else $error("fetch beat with unknown length");
`endif

endmodule

// File: tb/tb_mixed_width_text_span_raster_core.sv
`timescale 1ns / 1ps
// self-checking testbench for mixed_width_text_span_raster_core: directed table, then
// random text runs over several register settings; depends on mwtsr_pkg and the core

module tb_mixed_width_text_span_raster_core;

   localparam int CLOCK_PERIOD   = 10;
   localparam int MAX_SCALE      = 8;
   localparam int COORD_BITS     = 13;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int PEN_LIMIT      = 8191;
   localparam int SETTLE_CYCLES  = 64;      // margin before the registers are rewritten
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS    = 18;
   localparam int PHASES         = 6;
   localparam int RUN_LIMIT_NS   = 5_000_000;

   // package codes and constants used by the predictor and the table
   localparam mwtsr_pkg::action_type    ACT_TEXT       = mwtsr_pkg::ACT_TEXT;
   localparam mwtsr_pkg::action_type    ACT_GLYPH      = mwtsr_pkg::ACT_GLYPH;
   localparam mwtsr_pkg::action_type    ACT_NEWLINE    = mwtsr_pkg::ACT_NEWLINE;
   localparam mwtsr_pkg::kind_type      KIND_FETCH     = mwtsr_pkg::KIND_FETCH;
   localparam mwtsr_pkg::kind_type      KIND_SPAN      = mwtsr_pkg::KIND_SPAN;
   localparam mwtsr_pkg::kind_type      KIND_ERROR     = mwtsr_pkg::KIND_ERROR;
   localparam mwtsr_pkg::csr_index_type CSR_ORIGIN_ROW = mwtsr_pkg::CSR_ORIGIN_ROW;
   localparam mwtsr_pkg::csr_index_type CSR_ORIGIN_COL = mwtsr_pkg::CSR_ORIGIN_COL;
   localparam mwtsr_pkg::csr_index_type CSR_TEXT_COLOR = mwtsr_pkg::CSR_TEXT_COLOR;
   localparam mwtsr_pkg::csr_index_type CSR_SCALE      = mwtsr_pkg::CSR_SCALE;
   localparam logic [7:0]  CODE_LOW  = mwtsr_pkg::CODE_LOW;
   localparam logic [7:0]  CODE_HIGH = mwtsr_pkg::CODE_HIGH;
   localparam logic [13:0] ROW_CODES = mwtsr_pkg::ROW_CODES;
   localparam logic [8:0]  ASC_LEN   = mwtsr_pkg::ASC_LEN;
   localparam logic [8:0]  HZ_LEN    = mwtsr_pkg::HZ_LEN;
   localparam logic [7:0]  CELL_COLS = mwtsr_pkg::CELL_COLS;

   // action code the core must ignore
   localparam logic [1:0] ACT_IGNORED = 2'd3;

   // how a directed row is checked
   localparam logic [1:0] CHECK_MODEL = 2'd0;  // predicted beats
   localparam logic [1:0] CHECK_NONE  = 2'd1;  // no beat at all
   localparam logic [1:0] CHECK_ONE   = 2'd2;  // one beat typed into the table

   // kinds of random text run
   localparam int RUN_SHORT       = 0;
   localparam int RUN_FULL_DOUBLE = 2;

   typedef struct packed {
      logic [1:0]            kind;
      logic [21:0]           fetch_address;
      logic [8:0]            fetch_length;
      logic [COORD_BITS-1:0] span_row;
      logic [COORD_BITS-1:0] span_col;
      logic [3:0]            span_length;
      logic [23:0]           span_color;
      logic                  last;
   } result_beat_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  data_byte;
      logic [1:0]  check;
      logic [1:0]  kind;
      logic [21:0] fetch_address;
      logic [8:0]  fetch_length;
   } directed_row_type;

   // directed part: fetch extremes, every special case, error codes
   localparam int DIRECTED_ROWS = 27;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ACT_TEXT,    8'h00, CHECK_ONE,   KIND_FETCH, 22'd0,       9'd144}, // lowest ascii
      '{ACT_GLYPH,   8'hFF, CHECK_MODEL, KIND_FETCH, 22'd0,       9'd0},   // all bits set
      '{ACT_GLYPH,   8'h00, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},   // blank byte, counted
      '{ACT_GLYPH,   8'h80, CHECK_MODEL, KIND_FETCH, 22'd0,       9'd0},
      '{ACT_TEXT,    8'h7F, CHECK_ONE,   KIND_FETCH, 22'd18288,   9'd144}, // highest ascii
      '{ACT_GLYPH,   8'h01, CHECK_MODEL, KIND_FETCH, 22'd0,       9'd0},
      '{ACT_TEXT,    8'hA1, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},   // lead alone
      '{ACT_TEXT,    8'hA1, CHECK_ONE,   KIND_FETCH, 22'd0,       9'd288}, // lowest pair
      '{ACT_GLYPH,   8'hFF, CHECK_MODEL, KIND_FETCH, 22'd0,       9'd0},
      '{ACT_TEXT,    8'hFE, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},
      '{ACT_TEXT,    8'hFE, CHECK_ONE,   KIND_FETCH, 22'd2544480, 9'd288}, // highest pair
      '{ACT_TEXT,    8'h80, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},   // lead below range
      '{ACT_TEXT,    8'hA1, CHECK_ONE,   KIND_ERROR, 22'd0,       9'd0},
      '{ACT_TEXT,    8'hA1, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},
      '{ACT_TEXT,    8'hFF, CHECK_ONE,   KIND_ERROR, 22'd0,       9'd0},   // trail above range
      '{ACT_TEXT,    8'hFF, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},   // lead above range
      '{ACT_TEXT,    8'hA0, CHECK_ONE,   KIND_ERROR, 22'd0,       9'd0},
      '{ACT_TEXT,    8'hB0, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},
      '{ACT_GLYPH,   8'h55, CHECK_MODEL, KIND_FETCH, 22'd0,       9'd0},   // glyph while lead held
      '{ACT_TEXT,    8'hC1, CHECK_MODEL, KIND_FETCH, 22'd0,       9'd0},
      '{ACT_IGNORED, 8'hFF, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},
      '{ACT_NEWLINE, 8'h00, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},
      '{ACT_GLYPH,   8'hFF, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},   // no glyph active
      '{ACT_TEXT,    8'h20, CHECK_ONE,   KIND_FETCH, 22'd4608,    9'd144},
      '{ACT_TEXT,    8'hC5, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},
      '{ACT_NEWLINE, 8'hFF, CHECK_NONE,  KIND_FETCH, 22'd0,       9'd0},   // drops the lead
      '{ACT_TEXT,    8'h41, CHECK_ONE,   KIND_FETCH, 22'd9360,    9'd144}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_action = ACT_TEXT;
   logic [7:0]            req_data_byte = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_kind;
   logic [21:0]           rsp_fetch_address;
   logic [8:0]            rsp_fetch_length;
   logic [COORD_BITS-1:0] rsp_span_row;
   logic [COORD_BITS-1:0] rsp_span_col;
   logic [3:0]            rsp_span_length;
   logic [23:0]           rsp_span_color;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = CSR_ORIGIN_ROW;
   logic [23:0]           csr_data = 24'd0;

   // register copies and pen / glyph state of the predictor
   int cfg_origin_row, cfg_origin_col, cfg_color, cfg_scale;
   int pen_cells, lead_code, glyph_remaining, glyph_position, glyph_left_col;
   bit lead_held, glyph_wide;

   result_beat_type raster_beats[$];    // beats of the item just accepted
   result_beat_type expected_beats[$];  // beats still owed by the core
   bit              raster_counts;      // item was not simply ignored

   int failures      = 0;
   int items_counted = 0;
   bit steady        = 1'b0;       // no idling on either side
   bit hold_off_request = 1'b0;
   int hold_off_left = 0;

   mixed_width_text_span_raster_core #(
      .MAX_SCALE (MAX_SCALE),
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_fetch_address(rsp_fetch_address),
      .rsp_fetch_length (rsp_fetch_length),
      .rsp_span_row     (rsp_span_row),
      .rsp_span_col     (rsp_span_col),
      .rsp_span_length  (rsp_span_length),
      .rsp_span_color   (rsp_span_color),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int clip_coord(input int v);
      return (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic string beat_text(input result_beat_type b);
      return $sformatf("kind=%0d addr=%0d len=%0d row=%0d col=%0d slen=%0d color=%06h last=%0d",
                       b.kind, b.fetch_address, b.fetch_length, b.span_row, b.span_col,
                       b.span_length, b.span_color, b.last);
   endfunction

   task automatic add_raster_beat(input logic [1:0] kind, input int addr, input int len,
                                  input int row, input int col, input int slen, input int color);
      result_beat_type b;
      b.kind          = kind;
      b.fetch_address = addr[21:0];
      b.fetch_length  = len[8:0];
      b.span_row      = row[COORD_BITS-1:0];
      b.span_col      = col[COORD_BITS-1:0];
      b.span_length   = slen[3:0];
      b.span_color    = color[23:0];
      b.last          = 1'b0;
      raster_beats.push_back(b);
   endtask

   // a fetch arms a new glyph; its left column is fixed at fetch time
   task automatic open_glyph(input bit wide, input int s);
      glyph_wide      = wide;
      glyph_remaining = wide ? HZ_LEN : ASC_LEN;
      glyph_position  = 0;
      glyph_left_col  = clip_coord(cfg_origin_col + pen_cells * CELL_COLS * s);
   endtask

   task automatic move_pen(input int cells);
      pen_cells = (pen_cells + cells > PEN_LIMIT) ? PEN_LIMIT : pen_cells + cells;
   endtask

   task automatic rasterize(input logic [1:0] action, input logic [7:0] code);
      int s, per_row, dot_row, byte_col, c;
      result_beat_type b;
      raster_beats.delete();
      raster_counts = 1'b1;
      c = code;
      // out-of-range scale folds to the nearest legal one
      s = (cfg_scale == 0) ? 1 : (cfg_scale > MAX_SCALE) ? MAX_SCALE : cfg_scale;
      case (action)
         ACT_TEXT: begin
            if (lead_held) begin
               lead_held = 1'b0;
               if (lead_code < CODE_LOW || lead_code > CODE_HIGH || c < CODE_LOW ||
                   c > CODE_HIGH) begin
                  add_raster_beat(KIND_ERROR, 0, 0, 0, 0, 0, 0);
               end else begin
                  open_glyph(1'b1, s);
                  add_raster_beat(KIND_FETCH,
                                  (ROW_CODES * (lead_code - CODE_LOW) + (c - CODE_LOW)) * HZ_LEN,
                                  HZ_LEN, 0, 0, 0, 0);
               end
               move_pen(2);
            end else if (code[7]) begin
               lead_held = 1'b1;
               lead_code = c;
            end else begin
               open_glyph(1'b0, s);
               add_raster_beat(KIND_FETCH, c * ASC_LEN, ASC_LEN, 0, 0, 0, 0);
               move_pen(1);
            end
         end
         ACT_GLYPH: begin
            if (glyph_remaining != 0) begin
               per_row  = glyph_wide ? 6 : 3;
               dot_row  = glyph_position / per_row;
               byte_col = glyph_position % per_row;
               // msb first, one span per magnified row
               for (int i = 0; i < 8; i++) begin
                  if (code[7-i]) begin
                     for (int r = 0; r < s; r++) begin
                        add_raster_beat(KIND_SPAN, 0, 0,
                                        clip_coord(cfg_origin_row + dot_row * s + r),
                                        clip_coord(glyph_left_col + (byte_col * 8 + i) * s),
                                        s, cfg_color);
                     end
                  end
               end
               glyph_position  = (glyph_position + 1) & 9'h1FF;
               glyph_remaining = glyph_remaining - 1;
            end else begin
               raster_counts = 1'b0;
            end
         end
         ACT_NEWLINE: begin
            pen_cells       = 0;
            lead_held       = 1'b0;
            glyph_remaining = 0;
         end
         default: raster_counts = 1'b0;
      endcase
      if (raster_beats.size() > 0) begin
         b = raster_beats.pop_back();
         b.last = 1'b1;
         raster_beats.push_back(b);
      end
   endtask

   // ---------------------------------------------------------------- driving

   task automatic write_register(input mwtsr_pkg::csr_index_type index,
                                 input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_ORIGIN_ROW: cfg_origin_row = value[11:0];
         CSR_ORIGIN_COL: cfg_origin_col = value[11:0];
         CSR_TEXT_COLOR: cfg_color      = value;
         CSR_SCALE:      cfg_scale      = value[3:0];
         default: ;
      endcase
   endtask

   // narrow registers get junk in the unused upper bits
   task automatic load_settings(input logic [11:0] row, input logic [11:0] col,
                                input logic [23:0] color, input logic [3:0] scale);
      logic [23:0] junk;
      junk = 24'($urandom);
      write_register(CSR_ORIGIN_ROW, {junk[23:12], row});
      write_register(CSR_ORIGIN_COL, {junk[11:0], col});
      write_register(CSR_TEXT_COLOR, color);
      write_register(CSR_SCALE, {junk[19:0], scale});
      csr_valid <= 1'b0;
   endtask

   task automatic send_item(input logic [1:0] action, input logic [7:0] code,
                            input logic [1:0] check, input result_beat_type typed);
      req_valid     <= 1'b1;
      req_action    <= action;
      req_data_byte <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      rasterize(action, code);
      if (raster_counts) items_counted++;
      case (check)
         CHECK_MODEL: foreach (raster_beats[i]) expected_beats.push_back(raster_beats[i]);
         CHECK_ONE:   expected_beats.push_back(typed);
         default: ;
      endcase
      if (!steady) begin
         while ($urandom_range(99) < 32) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic send_plain(input logic [1:0] action, input logic [7:0] code);
      send_item(action, code, CHECK_MODEL, '0);
   endtask

   // one text code followed by glyph bytes, with noise in front of short runs
   task automatic send_text_run(input int run_kind);
      int pick, glyph_count;
      bit wide;
      logic [7:0] lead, trail, g;
      pick = $urandom_range(99);
      if (run_kind == RUN_SHORT) begin
         if (pick < 8) begin
            send_plain(ACT_NEWLINE, 8'($urandom));
         end else if (pick < 12) begin
            send_plain(ACT_IGNORED, 8'($urandom));
         end else if (pick < 16) begin
            send_plain(ACT_GLYPH, 8'($urandom));
         end else if (pick < 20) begin
            // pair cut short by a new line
            send_plain(ACT_TEXT, 8'($urandom_range(255, 128)));
            send_plain(ACT_NEWLINE, 8'($urandom));
         end
      end

      wide = (run_kind == RUN_FULL_DOUBLE) ||
             (run_kind == RUN_SHORT && $urandom_range(99) < 45);
      if (wide) begin
         lead  = 8'($urandom_range(CODE_HIGH, CODE_LOW));
         trail = 8'($urandom_range(CODE_HIGH, CODE_LOW));
         if (run_kind == RUN_SHORT && $urandom_range(99) < 12) begin
            lead  = 8'($urandom_range(255, 128));
            trail = 8'($urandom);
         end
         send_plain(ACT_TEXT, lead);
         send_plain(ACT_TEXT, trail);
      end else begin
         send_plain(ACT_TEXT, 8'($urandom_range(127, 0)));
      end

      // full runs walk the whole bitmap and a little past its end
      if (run_kind == RUN_SHORT) glyph_count = $urandom_range(8, 0);
      else glyph_count = (wide ? HZ_LEN : ASC_LEN) + $urandom_range(3, 1);
      for (int n = 0; n < glyph_count; n++) begin
         pick = $urandom_range(99);
         if (run_kind != RUN_SHORT) g = 8'($urandom & $urandom & $urandom);  // sparse
         else if (pick < 25) g = 8'hFF;
         else if (pick < 35) g = 8'h00;
         else g = 8'($urandom);
         send_plain(ACT_GLYPH, g);
      end
   endtask

   // idle point: every owed beat back and the queue given time to empty
   task automatic drain_core();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      result_beat_type got, want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_fetch_address, rsp_fetch_length, rsp_span_row,
                    rsp_span_col, rsp_span_length, rsp_span_color, rsp_last};
            if (expected_beats.size() == 0) begin
               failures++;
               $display("%0t: unexpected beat, expected none, got %s", $time, beat_text(got));
            end else begin
               want = expected_beats.pop_front();
               if (got != want) begin
                  failures++;
                  $display("%0t: beat mismatch, expected %s, got %s", $time,
                           beat_text(want), beat_text(got));
               end
            end
         end
         // long hold-off so the command queue fills and req_ready drops
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left    = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 32);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      result_beat_type typed;
      cfg_origin_row  = 0;
      cfg_origin_col  = 0;
      cfg_color       = 24'hFFFFFF;
      cfg_scale       = 1;
      pen_cells       = 0;
      lead_held       = 1'b0;
      lead_code       = 0;
      glyph_wide      = 1'b0;
      glyph_remaining = 0;
      glyph_position  = 0;
      glyph_left_col  = 0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table under reset settings
      foreach (DIRECTED[i]) begin
         typed = '0;
         typed.kind          = DIRECTED[i].kind;
         typed.fetch_address = DIRECTED[i].fetch_address;
         typed.fetch_length  = DIRECTED[i].fetch_length;
         typed.last          = 1'b1;
         send_item(DIRECTED[i].action, DIRECTED[i].data_byte, DIRECTED[i].check, typed);
      end
      req_valid <= 1'b0;

      for (int phase = 1; phase <= PHASES; phase++) begin
         drain_core();
         case (phase)
            1: load_settings(12'hFFF, 12'hFFF, 24'h000000, 4'd8);  // far corner, max scale
            2: load_settings(12'h000, 12'h000, 24'hFFFFFF, 4'd0);  // zero scale acts as one
            3: load_settings(12'($urandom), 12'($urandom), 24'($urandom), 4'd2);
            4: load_settings(12'($urandom), 12'hFFF, 24'($urandom), 4'd15);  // clamps to max
            5: load_settings(12'($urandom), 12'($urandom), 24'($urandom), 4'd1);
            default: load_settings(12'($urandom), 12'($urandom), 24'($urandom),
                                   4'($urandom));
         endcase
         steady = (phase == 2);
         if (phase == 1) hold_off_request = 1'b1;
         items_counted = 0;
         if (phase == 3) send_text_run(RUN_FULL_DOUBLE);
         while (items_counted < PHASE_ITEMS) send_text_run(RUN_SHORT);
         req_valid <= 1'b0;
      end

      drain_core();
      if (failures == 0) begin
         $display("tb_mixed_width_text_span_raster_core OK");
      end else begin
         $display("tb_mixed_width_text_span_raster_core NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
      $display("tb_mixed_width_text_span_raster_core NOT OK");
      $finish;
   end

endmodule
